>>> rtl/nec_pkg.sv
// ----------------------------------------------------------------------------
// NEC IR decoder package
// Widths, reset values, register indexes, timing windows and helpers shared
// by the NEC pulse decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package nec_pkg;

    // Field widths
    localparam int DUR_W     = 17;
    localparam int ELAPSED_W = 18;
    localparam int CODE_W    = 32;
    localparam int CNT_W     = 6;
    localparam int RPT_W     = 4;
    localparam int IDX_W     = 3;

    typedef logic [DUR_W-1:0]     dur_t;
    typedef logic [ELAPSED_W-1:0] elapsed_t;
    typedef logic [CODE_W-1:0]    code_t;

    // Saturation point of the elapsed-time counter
    localparam elapsed_t ELAPSED_MAX = '1;

    // Counted repeats needed for one repeat event
    localparam logic [RPT_W-1:0] REPEATS_PER_EVENT = 4'd2;

    // Frame length in bits
    localparam logic [CNT_W-1:0] FRAME_BITS = 6'd32;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_LEAD_LOW_MIN  = 3'd0;
    localparam logic [IDX_W-1:0] REG_LEAD_LOW_MAX  = 3'd1;
    localparam logic [IDX_W-1:0] REG_LEAD_HIGH_MIN = 3'd2;
    localparam logic [IDX_W-1:0] REG_LEAD_HIGH_MAX = 3'd3;
    localparam logic [IDX_W-1:0] REG_SHORT_MIN     = 3'd4;
    localparam logic [IDX_W-1:0] REG_SHORT_MAX     = 3'd5;
    localparam logic [IDX_W-1:0] REG_LONG_MIN      = 3'd6;
    localparam logic [IDX_W-1:0] REG_LONG_MAX      = 3'd7;

    // Configuration reset values (microseconds)
    localparam dur_t RST_LEAD_LOW_MIN  = 17'd8500;
    localparam dur_t RST_LEAD_LOW_MAX  = 17'd9500;
    localparam dur_t RST_LEAD_HIGH_MIN = 17'd4000;
    localparam dur_t RST_LEAD_HIGH_MAX = 17'd5000;
    localparam dur_t RST_SHORT_MIN     = 17'd340;
    localparam dur_t RST_SHORT_MAX     = 17'd780;
    localparam dur_t RST_LONG_MIN      = 17'd1460;
    localparam dur_t RST_LONG_MAX      = 17'd1900;

    // Repeat leader high window, both bounds exclusive
    localparam dur_t REP_HIGH_LO = 17'd1750;
    localparam dur_t REP_HIGH_HI = 17'd2750;

    // Gap windows that qualify a repeat, bounds exclusive
    localparam elapsed_t REP_GAP_LO   = 18'd44500;
    localparam elapsed_t REP_GAP_HI   = 18'd45500;
    localparam elapsed_t REP_GAP_LONG = 18'd107500;

    // Event kinds
    localparam logic EV_FRAME  = 1'b0;
    localparam logic EV_REPEAT = 1'b1;

    // Saturating add of two elapsed-time values
    function automatic elapsed_t sat_add(input elapsed_t a, input elapsed_t b);
        logic [ELAPSED_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[ELAPSED_W] ? ELAPSED_MAX : s[ELAPSED_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/nec_ir_pulse_decoder_top.sv
// ----------------------------------------------------------------------------
// NEC IR pulse decoder
// Decodes NEC remote frames and repeat events from measured line pulses.
// ----------------------------------------------------------------------------
//
// Each request is one measured pulse (level, length in microseconds). The
// block takes one request per clock while in_stall is low: a request is
// captured in an input register and fully decoded, once the decode stage
// advances, by window compares, a saturating elapsed-time add and a 32-bit
// shift, with the result written to an output register. in_stall rises only
// while a held result blocks the decode stage. At most one result per pulse:
// a decoded frame (event_kind 0) or, on every second counted repeat, a repeat
// event (event_kind 1) carrying the last frame's bytes. Write the timing
// window registers only while the block is idle.
`default_nettype none

module nec_ir_pulse_decoder_top
    import nec_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    // configuration write port
    input  wire logic             cfg_we,
    input  wire logic [IDX_W-1:0] cfg_index,
    input  wire logic [DUR_W-1:0] cfg_wdata,
    // pulse channel
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic             level,
    input  wire logic [DUR_W-1:0] duration_us,
    // event channel
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic                  event_kind,
    output logic [7:0]            byte0,
    output logic [7:0]            byte1,
    output logic [7:0]            byte2,
    output logic [7:0]            byte3
);

    // Decoder phases
    localparam logic [1:0] PH_IDLE      = 2'd0;
    localparam logic [1:0] PH_LEAD_HIGH = 2'd1;
    localparam logic [1:0] PH_BIT_LOW   = 2'd2;
    localparam logic [1:0] PH_BIT_HIGH  = 2'd3;

    // Configuration registers
    dur_t lead_low_min_reg, lead_low_max_reg, lead_high_min_reg, lead_high_max_reg;
    dur_t short_min_reg, short_max_reg, long_min_reg, long_max_reg;

    // Input stage
    logic             in_valid_reg;
    logic             level_reg;
    dur_t             dur_reg;

    // Decoder state
    logic [1:0]       phase_reg, phase_next;
    logic [CNT_W-1:0] bit_count_reg, bit_count_next;
    code_t            shift_reg, shift_next;
    code_t            last_code_reg, last_code_next;
    elapsed_t         elapsed_reg, elapsed_next;
    elapsed_t         gap_reg, gap_next;
    logic [RPT_W-1:0] repeat_count_reg, repeat_count_next;

    // Result stage
    logic             out_valid_reg;
    logic             event_kind_reg;
    code_t            code_out_reg;

    // Decode outputs
    logic             emit;
    logic             emit_kind;
    code_t            emit_code;

    logic             proc_ready;
    logic             fire;
    logic             accept;

    elapsed_t         dur_ext;
    elapsed_t         elapsed_add;
    elapsed_t         gap_eff;
    logic             lead_low_ok, lead_high_ok, rep_high_ok, rep_gap_ok;
    logic             short_low_ok, zero_high_ok, one_high_ok;
    logic [RPT_W-1:0] repeat_inc;
    logic [CNT_W-1:0] bit_count_inc;
    code_t            shift_in;

    // Handshake: decode advances when the result slot is free or draining
    assign proc_ready = !out_valid_reg || !out_stall;
    assign fire       = in_valid_reg && proc_ready;
    assign in_stall   = in_valid_reg && !proc_ready;
    assign accept     = in_valid && !in_stall;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_low_min_reg  <= RST_LEAD_LOW_MIN;
            lead_low_max_reg  <= RST_LEAD_LOW_MAX;
            lead_high_min_reg <= RST_LEAD_HIGH_MIN;
            lead_high_max_reg <= RST_LEAD_HIGH_MAX;
            short_min_reg     <= RST_SHORT_MIN;
            short_max_reg     <= RST_SHORT_MAX;
            long_min_reg      <= RST_LONG_MIN;
            long_max_reg      <= RST_LONG_MAX;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LEAD_LOW_MIN:  lead_low_min_reg  <= cfg_wdata;
                REG_LEAD_LOW_MAX:  lead_low_max_reg  <= cfg_wdata;
                REG_LEAD_HIGH_MIN: lead_high_min_reg <= cfg_wdata;
                REG_LEAD_HIGH_MAX: lead_high_max_reg <= cfg_wdata;
                REG_SHORT_MIN:     short_min_reg     <= cfg_wdata;
                REG_SHORT_MAX:     short_max_reg     <= cfg_wdata;
                REG_LONG_MIN:      long_min_reg      <= cfg_wdata;
                REG_LONG_MAX:      long_max_reg      <= cfg_wdata;
                default:           lead_low_min_reg  <= lead_low_min_reg;
            endcase
        end
    end

    // Capture the incoming request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (accept)
            in_valid_reg <= 1'b1;
        else if (fire)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            level_reg <= level;
            dur_reg   <= duration_us;
        end
    end

    // Window compares
    assign dur_ext      = {1'b0, dur_reg};
    assign elapsed_add  = sat_add(elapsed_reg, dur_ext);
    assign lead_low_ok  = (dur_reg >= lead_low_min_reg) && (dur_reg <= lead_low_max_reg);
    assign lead_high_ok = (dur_reg >= lead_high_min_reg) && (dur_reg <= lead_high_max_reg);
    assign rep_high_ok  = (dur_reg > REP_HIGH_LO) && (dur_reg < REP_HIGH_HI);
    assign rep_gap_ok   = ((gap_reg > REP_GAP_LO) && (gap_reg < REP_GAP_HI))
                        || (gap_reg > REP_GAP_LONG);
    assign short_low_ok = (dur_reg >= short_min_reg) && (dur_reg <= short_max_reg);
    assign zero_high_ok = (dur_reg > short_min_reg) && (dur_reg < short_max_reg);
    assign one_high_ok  = (dur_reg > long_min_reg) && (dur_reg < long_max_reg);
    assign repeat_inc   = repeat_count_reg + 1'b1;
    assign bit_count_inc = bit_count_reg + 1'b1;
    assign shift_in     = {one_high_ok && !zero_high_ok, shift_reg[CODE_W-1:1]};
    // A repeat-length high moves the reference point to the leader start
    assign gap_eff      = rep_high_ok ? '0 : gap_reg;

    // Decode one pulse
    always_comb
    begin
        phase_next        = phase_reg;
        bit_count_next    = bit_count_reg;
        shift_next        = shift_reg;
        last_code_next    = last_code_reg;
        elapsed_next      = elapsed_add;
        gap_next          = gap_reg;
        repeat_count_next = repeat_count_reg;
        emit              = 1'b0;
        emit_kind         = EV_FRAME;
        emit_code         = last_code_reg;

        unique case (phase_reg)
            PH_IDLE:
            begin
                // a high pulse in idle only adds time
                if (!level_reg && lead_low_ok)
                begin
                    gap_next     = elapsed_reg;
                    elapsed_next = dur_ext;
                    phase_next   = PH_LEAD_HIGH;
                end
            end
            PH_LEAD_HIGH:
            begin
                if (!level_reg)
                begin
                    elapsed_next = sat_add(gap_reg, elapsed_add);
                    gap_next     = '0;
                    phase_next   = PH_IDLE;
                end
                else if (rep_high_ok && rep_gap_ok)
                begin
                    gap_next          = '0;
                    phase_next        = PH_IDLE;
                    repeat_count_next = repeat_inc;
                    if (repeat_inc == REPEATS_PER_EVENT)
                    begin
                        repeat_count_next = '0;
                        emit              = 1'b1;
                        emit_kind         = EV_REPEAT;
                    end
                end
                else if (lead_high_ok)
                begin
                    gap_next       = gap_eff;
                    bit_count_next = '0;
                    shift_next     = '0;
                    phase_next     = PH_BIT_LOW;
                end
                else
                begin
                    elapsed_next = sat_add(gap_eff, elapsed_add);
                    gap_next     = '0;
                    phase_next   = PH_IDLE;
                end
            end
            PH_BIT_LOW:
            begin
                if (level_reg || !short_low_ok)
                begin
                    elapsed_next = sat_add(gap_reg, elapsed_add);
                    gap_next     = '0;
                    phase_next   = PH_IDLE;
                end
                else
                    phase_next = PH_BIT_HIGH;
            end
            PH_BIT_HIGH:
            begin
                if (!level_reg || !(zero_high_ok || one_high_ok))
                begin
                    elapsed_next = sat_add(gap_reg, elapsed_add);
                    gap_next     = '0;
                    phase_next   = PH_IDLE;
                end
                else if (bit_count_inc == FRAME_BITS)
                begin
                    // frame complete: latch code and restart the reference
                    shift_next        = shift_in;
                    last_code_next    = shift_in;
                    repeat_count_next = '0;
                    elapsed_next      = '0;
                    gap_next          = '0;
                    bit_count_next    = '0;
                    phase_next        = PH_IDLE;
                    emit              = 1'b1;
                    emit_kind         = EV_FRAME;
                    emit_code         = shift_in;
                end
                else
                begin
                    shift_next     = shift_in;
                    bit_count_next = bit_count_inc;
                    phase_next     = PH_BIT_LOW;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Advance decoder state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            bit_count_reg    <= '0;
            shift_reg        <= '0;
            last_code_reg    <= '0;
            elapsed_reg      <= ELAPSED_MAX;
            gap_reg          <= '0;
            repeat_count_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg        <= phase_next;
            bit_count_reg    <= bit_count_next;
            shift_reg        <= shift_next;
            last_code_reg    <= last_code_next;
            elapsed_reg      <= elapsed_next;
            gap_reg          <= gap_next;
            repeat_count_reg <= repeat_count_next;
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire)
            out_valid_reg <= emit;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            event_kind_reg <= emit_kind;
            code_out_reg   <= emit_code;
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_kind = event_kind_reg;
    assign byte0      = code_out_reg[7:0];
    assign byte1      = code_out_reg[15:8];
    assign byte2      = code_out_reg[23:16];
    assign byte3      = code_out_reg[31:24];

    // Leader gap is always cleared whenever the decoder is idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (gap_reg == '0))
        else $error("leader gap left over in idle");

    // Bit counter never reaches the frame length
    assert property (@(posedge clk) disable iff (!rst_n)
        bit_count_reg < FRAME_BITS)
        else $error("bit counter overran frame length");

    // A new result only comes from a decoded request
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg)) |-> $past(fire))
        else $error("result appeared without a decoded request");

    // Input stage stalls only when a result is blocked downstream
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall))
        else $error("input stalled with result slot free");

endmodule

`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// NEC IR pulse decoder testbench
// Drives measured line pulses into the decoder and checks every frame and
// repeat event against a cycle-free decoder model kept in this file. A short
// directed table covers window edges, wrong levels, repeat gap rules and one
// full frame. Random frames, repeats and noise then run under several timing
// window settings, with bursty requests, receiver stalls and one long
// receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import nec_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 11;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int DRAIN_CYCLES   = 6;
    localparam int NUM_REGS       = 8;
    localparam int FRAME_PULSES   = 2 + 2 * CODE_W;
    localparam int HOLD_AFTER     = 300;
    localparam int HOLD_CYCLES    = 600;
    localparam int MAX_REPORTS    = 100;
    localparam dur_t DUR_TOP      = '1;

    // Receiver stall modes
    localparam int SINK_FREE   = 0;
    localparam int SINK_RANDOM = 1;
    localparam int SINK_TOGGLE = 2;

    typedef enum logic [1:0] {ST_IDLE, ST_LEAD_HIGH, ST_BIT_LOW, ST_BIT_HIGH} dec_state_t;

    typedef struct packed {
        logic  kind;
        code_t code;
    } ir_event_t;

    // One directed step: a single pulse, or a whole frame when frame is set
    typedef struct packed {
        logic  frame;
        logic  lv;
        dur_t  d;
        code_t word;
        logic  typed;
        logic  want;
        logic  kind;
    } row_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [DUR_W-1:0] cfg_wdata;
    logic             in_valid;
    logic             in_stall;
    logic             level;
    logic [DUR_W-1:0] duration_us;
    logic             out_valid;
    logic             out_stall;
    logic             event_kind;
    logic [7:0]       byte0;
    logic [7:0]       byte1;
    logic [7:0]       byte2;
    logic [7:0]       byte3;

    // Decoder model state
    dec_state_t  st;
    logic [5:0]  nbits;
    code_t       shreg;
    code_t       last_word;
    elapsed_t    since_ref;
    elapsed_t    leader_gap;
    logic [3:0]  rpt_cnt;
    dur_t        win [NUM_REGS];
    dur_t        cfg_plan [NUM_REGS];

    ir_event_t   expected_events [$];
    int          mismatches;
    int          pulses_sent;
    int          burst_left;
    int          frames_seen;
    int          repeats_seen;
    int          settings_applied;
    bit          edge_picks;

    row_t directed_rows [0:22] = '{
        '{1'b0, 1'b1, 17'd131071, 32'h0, 1'b1, 1'b0, EV_FRAME},
        '{1'b0, 1'b0, 17'd9000,   32'h0, 1'b1, 1'b0, EV_FRAME},
        '{1'b0, 1'b1, 17'd2250,   32'h0, 1'b1, 1'b0, EV_FRAME},
        '{1'b0, 1'b1, 17'd33500,  32'h0, 1'b0, 1'b0, EV_FRAME},
        '{1'b0, 1'b0, 17'd9000,   32'h0, 1'b1, 1'b0, EV_FRAME},
        '{1'b0, 1'b1, 17'd2250,   32'h0, 1'b1, 1'b1, EV_REPEAT},
        '{1'b0, 1'b0, 17'd8499,   32'h0, 1'b1, 1'b0, EV_FRAME},
        '{1'b0, 1'b0, 17'd8500,   32'h0, 1'b1, 1'b0, EV_FRAME},
        '{1'b0, 1'b0, 17'd0,      32'h0, 1'b1, 1'b0, EV_FRAME},
        '{1'b0, 1'b0, 17'd9500,   32'h0, 1'b1, 1'b0, EV_FRAME},
        '{1'b0, 1'b1, 17'd3999,   32'h0, 1'b1, 1'b0, EV_FRAME},
        '{1'b0, 1'b0, 17'd9000,   32'h0, 1'b1, 1'b0, EV_FRAME},
        '{1'b0, 1'b1, 17'd5000,   32'h0, 1'b1, 1'b0, EV_FRAME},
        '{1'b0, 1'b1, 17'd560,    32'h0, 1'b1, 1'b0, EV_FRAME},
        '{1'b1, 1'b0, 17'd0,      32'h807F01FE, 1'b1, 1'b1, EV_FRAME},
        '{1'b0, 1'b1, 17'd44600,  32'h0, 1'b0, 1'b0, EV_FRAME},
        '{1'b0, 1'b0, 17'd9000,   32'h0, 1'b0, 1'b0, EV_FRAME},
        '{1'b0, 1'b1, 17'd2250,   32'h0, 1'b1, 1'b0, EV_FRAME},
        '{1'b0, 1'b1, 17'd33250,  32'h0, 1'b0, 1'b0, EV_FRAME},
        '{1'b0, 1'b0, 17'd9000,   32'h0, 1'b0, 1'b0, EV_FRAME},
        '{1'b0, 1'b1, 17'd2250,   32'h0, 1'b1, 1'b0, EV_FRAME},
        '{1'b0, 1'b0, 17'd131071, 32'h0, 1'b1, 1'b0, EV_FRAME},
        '{1'b0, 1'b1, 17'd0,      32'h0, 1'b1, 1'b0, EV_FRAME}
    };

    nec_ir_pulse_decoder_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .level       (level),
        .duration_us (duration_us),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .event_kind  (event_kind),
        .byte0       (byte0),
        .byte1       (byte1),
        .byte2       (byte2),
        .byte3       (byte3)
    );

    // Generate the clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // End the run if it hangs
    initial
    begin : watchdog
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------

    function automatic elapsed_t add_sat(input elapsed_t a, input elapsed_t b);
        logic [ELAPSED_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, ELAPSED_MAX}) ? ELAPSED_MAX : s[ELAPSED_W-1:0];
    endfunction

    // Drop back to idle, keeping the old reference point
    function automatic void drop_to_idle();
        since_ref  = add_sat(leader_gap, since_ref);
        leader_gap = '0;
        st         = ST_IDLE;
    endfunction

    function automatic void reset_model();
        st         = ST_IDLE;
        nbits      = '0;
        shreg      = '0;
        last_word  = '0;
        since_ref  = ELAPSED_MAX;
        leader_gap = '0;
        rpt_cnt    = '0;
        win[REG_LEAD_LOW_MIN]  = RST_LEAD_LOW_MIN;
        win[REG_LEAD_LOW_MAX]  = RST_LEAD_LOW_MAX;
        win[REG_LEAD_HIGH_MIN] = RST_LEAD_HIGH_MIN;
        win[REG_LEAD_HIGH_MAX] = RST_LEAD_HIGH_MAX;
        win[REG_SHORT_MIN]     = RST_SHORT_MIN;
        win[REG_SHORT_MAX]     = RST_SHORT_MAX;
        win[REG_LONG_MIN]      = RST_LONG_MIN;
        win[REG_LONG_MAX]      = RST_LONG_MAX;
    endfunction

    // Advance the model by one pulse; return 1 when it yields an event
    function automatic logic nec_decode_step(input logic lv, input dur_t d,
                                             output ir_event_t ev);
        logic     hit;
        logic     counted;
        logic     b;
        elapsed_t g;
        hit = 1'b0;
        ev  = '0;
        case (st)
            ST_IDLE:
            begin
                if (lv)
                    since_ref = add_sat(since_ref, elapsed_t'(d));
                else
                begin
                    leader_gap = since_ref;
                    since_ref  = elapsed_t'(d);
                    if (d >= win[REG_LEAD_LOW_MIN] && d <= win[REG_LEAD_LOW_MAX])
                        st = ST_LEAD_HIGH;
                    else
                        drop_to_idle();
                end
            end
            ST_LEAD_HIGH:
            begin
                since_ref = add_sat(since_ref, elapsed_t'(d));
                if (!lv)
                    drop_to_idle();
                else
                begin
                    counted = 1'b0;
                    // Repeat high: the leader start becomes the reference point
                    if (d > REP_HIGH_LO && d < REP_HIGH_HI)
                    begin
                        g          = leader_gap;
                        leader_gap = '0;
                        if ((g > REP_GAP_LO && g < REP_GAP_HI) || g > REP_GAP_LONG)
                        begin
                            counted = 1'b1;
                            st      = ST_IDLE;
                            rpt_cnt = rpt_cnt + 1'b1;
                            if (rpt_cnt == REPEATS_PER_EVENT)
                            begin
                                rpt_cnt = '0;
                                ev.kind = EV_REPEAT;
                                ev.code = last_word;
                                hit     = 1'b1;
                            end
                        end
                    end
                    // Otherwise test against the frame leader window
                    if (!counted)
                    begin
                        if (d >= win[REG_LEAD_HIGH_MIN] && d <= win[REG_LEAD_HIGH_MAX])
                        begin
                            nbits = '0;
                            shreg = '0;
                            st    = ST_BIT_LOW;
                        end
                        else
                            drop_to_idle();
                    end
                end
            end
            ST_BIT_LOW:
            begin
                since_ref = add_sat(since_ref, elapsed_t'(d));
                if (lv || d < win[REG_SHORT_MIN] || d > win[REG_SHORT_MAX])
                    drop_to_idle();
                else
                    st = ST_BIT_HIGH;
            end
            default:
            begin
                since_ref = add_sat(since_ref, elapsed_t'(d));
                if (!lv)
                    drop_to_idle();
                else if ((d > win[REG_SHORT_MIN] && d < win[REG_SHORT_MAX]) ||
                         (d > win[REG_LONG_MIN] && d < win[REG_LONG_MAX]))
                begin
                    b     = !(d > win[REG_SHORT_MIN] && d < win[REG_SHORT_MAX]);
                    shreg = {b, shreg[CODE_W-1:1]};
                    nbits = nbits + 1'b1;
                    if (nbits < FRAME_BITS)
                        st = ST_BIT_LOW;
                    else
                    begin
                        // Frame complete: its end is the new reference point
                        last_word  = shreg;
                        rpt_cnt    = '0;
                        since_ref  = '0;
                        leader_gap = '0;
                        nbits      = '0;
                        st         = ST_IDLE;
                        ev.kind    = EV_FRAME;
                        ev.code    = shreg;
                        hit        = 1'b1;
                    end
                end
                else
                    drop_to_idle();
            end
        endcase
        return hit;
    endfunction

    // ------------------------------------------------------------------
    // Duration pickers
    // ------------------------------------------------------------------

    function automatic dur_t noise_dur();
        if ($urandom_range(0, 1) == 1)
            return dur_t'($urandom_range(0, 12000));
        return dur_t'($urandom);
    endfunction

    // Pick inside an inclusive window, favoring its edges
    function automatic dur_t pick_incl(input dur_t lo, input dur_t hi);
        int unsigned r;
        r = $urandom_range(0, 7);
        if (lo > hi)
            return noise_dur();
        if (r == 0)
            return lo;
        if (r == 1)
            return hi;
        return dur_t'($urandom_range(hi, lo));
    endfunction

    // Pick inside an exclusive window; now and then hit a bound on purpose
    function automatic dur_t pick_excl(input dur_t lo, input dur_t hi);
        int unsigned r;
        r = $urandom_range(0, 7);
        if (edge_picks && $urandom_range(0, 127) == 0)
            return ($urandom_range(0, 1) == 1) ? lo : hi;
        if (int'(hi) - int'(lo) < 2)
            return noise_dur();
        if (r == 0)
            return lo + 1'b1;
        if (r == 1)
            return hi - 1'b1;
        return dur_t'($urandom_range(hi - 1'b1, lo + 1'b1));
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Send one pulse request in bursts; predict once it is accepted
    task automatic issue(input logic lv, input dur_t d, input logic typed,
                         input logic want, input ir_event_t typed_ev);
        ir_event_t ev;
        logic      got;
        int        gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid    <= 1'b1;
        level       <= lv;
        duration_us <= d;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        burst_left--;
        pulses_sent++;
        got = nec_decode_step(lv, d, ev);
        if (typed)
        begin
            if (want)
                expected_events.push_back(typed_ev);
        end
        else if (got)
            expected_events.push_back(ev);
    endtask

    // Bring the decoder back to idle with a pulse of the wrong level
    task automatic back_to_idle();
        while (st != ST_IDLE)
            issue(st == ST_BIT_LOW, noise_dur(), 1'b0, 1'b0, '0);
    endtask

    // Send a full frame; now and then spoil one pulse of it
    task automatic send_frame(input code_t word, input logic typed);
        int        bad_at;
        logic      lv;
        dur_t      d;
        ir_event_t ev;
        bad_at  = (!typed && $urandom_range(0, 4) == 0) ?
                  $urandom_range(0, FRAME_PULSES - 1) : -1;
        ev.kind = EV_FRAME;
        ev.code = word;
        back_to_idle();
        for (int k = 0; k < FRAME_PULSES; k++)
        begin
            if (k == 0)
            begin
                lv = 1'b0;
                d  = pick_incl(win[REG_LEAD_LOW_MIN], win[REG_LEAD_LOW_MAX]);
            end
            else if (k == 1)
            begin
                lv = 1'b1;
                d  = pick_incl(win[REG_LEAD_HIGH_MIN], win[REG_LEAD_HIGH_MAX]);
            end
            else if (k % 2 == 0)
            begin
                lv = 1'b0;
                d  = pick_incl(win[REG_SHORT_MIN], win[REG_SHORT_MAX]);
            end
            else
            begin
                lv = 1'b1;
                d  = word[(k - 2) / 2] ? pick_excl(win[REG_LONG_MIN], win[REG_LONG_MAX])
                                       : pick_excl(win[REG_SHORT_MIN], win[REG_SHORT_MAX]);
            end
            if (k == bad_at)
            begin
                if ($urandom_range(0, 1) == 1)
                    lv = ~lv;
                else
                    d = noise_dur();
            end
            issue(lv, d, typed && k == FRAME_PULSES - 1, 1'b1, ev);
        end
    endtask

    // Pad the idle time up to a chosen gap, then send a repeat leader
    task automatic send_repeat();
        elapsed_t target;
        elapsed_t pad;
        dur_t     d;
        int       sel;
        back_to_idle();
        sel = $urandom_range(0, 9);
        if (sel == 0)
            target = ($urandom_range(0, 1) == 1) ? REP_GAP_LO : REP_GAP_HI;
        else if (sel < 5)
            target = elapsed_t'($urandom_range(REP_GAP_HI - 1, REP_GAP_LO + 1));
        else if (sel == 5)
            target = REP_GAP_LONG;
        else if (sel == 6)
            target = ELAPSED_MAX;
        else if (sel < 9)
            target = elapsed_t'($urandom_range(REP_GAP_LONG + 40000, REP_GAP_LONG + 1));
        else
            target = elapsed_t'($urandom_range(0, 60000));
        while (since_ref < target)
        begin
            pad = target - since_ref;
            issue(1'b1, (pad > DUR_TOP) ? DUR_TOP : dur_t'(pad), 1'b0, 1'b0, '0);
        end
        issue(1'b0, pick_incl(win[REG_LEAD_LOW_MIN], win[REG_LEAD_LOW_MAX]),
              1'b0, 1'b0, '0);
        if ($urandom_range(0, 15) == 0)
            d = ($urandom_range(0, 1) == 1) ? REP_HIGH_LO : REP_HIGH_HI;
        else
            d = dur_t'($urandom_range(REP_HIGH_HI - 1, REP_HIGH_LO + 1));
        issue(1'b1, d, 1'b0, 1'b0, '0);
    endtask

    // Mix frames, repeats and noise until the budget of pulses is spent
    task automatic run_random(input int budget);
        int    start;
        int    r;
        code_t word;
        start = pulses_sent;
        while (pulses_sent - start < budget)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
            begin
                case ($urandom_range(0, 9))
                    0:       word = '0;
                    1:       word = '1;
                    default: word = $urandom;
                endcase
                send_frame(word, 1'b0);
            end
            else if (r < 80)
                send_repeat();
            else
                repeat ($urandom_range(1, 5))
                    issue(1'($urandom_range(0, 1)), noise_dur(), 1'b0, 1'b0, '0);
        end
    endtask

    function automatic void fill_plan(input dur_t llmin, input dur_t llmax,
                                      input dur_t lhmin, input dur_t lhmax,
                                      input dur_t smin, input dur_t smax,
                                      input dur_t lmin, input dur_t lmax);
        cfg_plan[REG_LEAD_LOW_MIN]  = llmin;
        cfg_plan[REG_LEAD_LOW_MAX]  = llmax;
        cfg_plan[REG_LEAD_HIGH_MIN] = lhmin;
        cfg_plan[REG_LEAD_HIGH_MAX] = lhmax;
        cfg_plan[REG_SHORT_MIN]     = smin;
        cfg_plan[REG_SHORT_MAX]     = smax;
        cfg_plan[REG_LONG_MIN]      = lmin;
        cfg_plan[REG_LONG_MAX]      = lmax;
    endfunction

    // Wait for the block to go idle, then write all window registers
    task automatic apply_config();
        in_valid <= 1'b0;
        while (expected_events.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        for (int i = 0; i < NUM_REGS; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= IDX_W'(i);
            cfg_wdata <= cfg_plan[i];
            @(posedge clk);
            win[i] = cfg_plan[i];
        end
        cfg_we     <= 1'b0;
        burst_left = 0;
        settings_applied++;
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < MAX_REPORTS)
            $display("[%0t] MISMATCH %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    // Stall the receiver on its own pattern, with one long hold-off
    initial
    begin : event_sink
        int mode;
        int mode_left;
        int hold_left;
        bit hold_done;
        out_stall = 1'b0;
        mode      = SINK_FREE;
        mode_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                mode      = $urandom_range(SINK_FREE, SINK_TOGGLE);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (!hold_done && out_valid && pulses_sent > HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else if (mode == SINK_RANDOM)
                out_stall <= ($urandom_range(0, 99) < 40);
            else if (mode == SINK_TOGGLE)
                out_stall <= ~out_stall;
            else
                out_stall <= 1'b0;
        end
    end

    // Compare each accepted event with the oldest expectation
    always @(posedge clk)
    begin
        ir_event_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_events.size() == 0)
                report_mismatch("event with nothing pending",
                                {byte3, byte2, byte1, byte0}, '0);
            else
            begin
                want = expected_events.pop_front();
                check_field("event_kind", 32'(event_kind), 32'(want.kind));
                check_field("byte0", 32'(byte0), 32'(want.code[7:0]));
                check_field("byte1", 32'(byte1), 32'(want.code[15:8]));
                check_field("byte2", 32'(byte2), 32'(want.code[23:16]));
                check_field("byte3", 32'(byte3), 32'(want.code[31:24]));
                if (want.kind == EV_REPEAT)
                    repeats_seen++;
                else
                    frames_seen++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin : main_flow
        row_t      row;
        ir_event_t ev;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_wdata        = '0;
        in_valid         = 1'b0;
        level            = 1'b0;
        duration_us      = '0;
        mismatches       = 0;
        pulses_sent      = 0;
        burst_left       = 0;
        frames_seen      = 0;
        repeats_seen     = 0;
        settings_applied = 0;
        edge_picks       = 1'b0;
        reset_model();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed table under reset windows
        foreach (directed_rows[i])
        begin
            row     = directed_rows[i];
            ev.kind = row.kind;
            ev.code = row.word;
            if (row.frame)
                send_frame(row.word, 1'b1);
            else
                issue(row.lv, row.d, row.typed, row.want, ev);
        end
        edge_picks = 1'b1;
        run_random(330);

        // Jittered windows around the nominal timing
        fill_plan(RST_LEAD_LOW_MIN - dur_t'($urandom_range(0, 800)),
                  RST_LEAD_LOW_MAX + dur_t'($urandom_range(0, 800)),
                  RST_LEAD_HIGH_MIN - dur_t'($urandom_range(0, 500)),
                  RST_LEAD_HIGH_MAX + dur_t'($urandom_range(0, 500)),
                  RST_SHORT_MIN - dur_t'($urandom_range(0, 200)),
                  RST_SHORT_MAX + dur_t'($urandom_range(0, 300)),
                  RST_LONG_MIN - dur_t'($urandom_range(0, 300)),
                  RST_LONG_MAX + dur_t'($urandom_range(0, 600)));
        apply_config();
        run_random(330);

        // Widest open windows
        fill_plan('0, DUR_TOP, '0, DUR_TOP, '0, DUR_TOP, '0, DUR_TOP);
        apply_config();
        run_random(220);

        // Every register at its top value
        fill_plan(DUR_TOP, DUR_TOP, DUR_TOP, DUR_TOP, DUR_TOP, DUR_TOP, DUR_TOP, DUR_TOP);
        apply_config();
        run_random(130);

        // Every register at zero
        fill_plan('0, '0, '0, '0, '0, '0, '0, '0);
        apply_config();
        run_random(130);

        // Frame leader window over the repeat window, overlapping bit windows
        fill_plan(17'd7000, 17'd11000, 17'd1000, 17'd5000,
                  17'd300, 17'd2000, 17'd500, 17'd1900);
        apply_config();
        run_random(330);

        // Back to nominal timing
        fill_plan(RST_LEAD_LOW_MIN, RST_LEAD_LOW_MAX, RST_LEAD_HIGH_MIN, RST_LEAD_HIGH_MAX,
                  RST_SHORT_MIN, RST_SHORT_MAX, RST_LONG_MIN, RST_LONG_MAX);
        apply_config();
        run_random(330);

        // Drain outstanding events
        in_valid <= 1'b0;
        while (expected_events.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d pulses across %0d window settings after the reset ones.",
                 pulses_sent, settings_applied);
        $display("Checked %0d frames and %0d repeat events; %0d mismatches.",
                 frames_seen, repeats_seen, mismatches);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
rtl/nec_pkg.sv
rtl/nec_ir_pulse_decoder_top.sv
tb/testbench.sv
